// ===== design/mme_pkg.sv =====
package mme_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 4;
   localparam int ELEM_W   = 16;
   localparam int RESULT_W = 36;
   localparam int DIM_W    = 5;
   localparam int CSR_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } command_type;

   localparam logic [CSR_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ERROR
   } state_type;

endpackage

// ===== design/matrix_multiply_engine_unit.sv =====
// Dense matrix product engine: A and B are held in two on-chip stores of MAX_DIM x MAX_DIM
// signed Q8.8 elements, loaded one element per transaction, each written as it is accepted. A
// compute transaction on row i streams out cols_b Q20.16 results C[i][j] in ascending j, the
// final one marked last. One multiply-accumulate unit is shared by every product, fed by a
// single read port on each store, so a compute transaction keeps the block busy: for each
// column it issues inner_dim reads, the products then pass the read, multiply and accumulate
// registers, and the column is handed to the output register, waiting while the consumer
// stalls. An out-of-range index gives one flagged result and no store update. Stores are
// not cleared at reset.
module matrix_multiply_engine_unit
   import mme_pkg::*;
#(
   parameter int MAX_DIM     = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [IDX_W-1:0]           req_row_index,
   input  logic [IDX_W-1:0]           req_col_index,
   input  logic signed [ELEM_W-1:0]   req_element_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [IDX_W-1:0]           rsp_result_col,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic                       rsp_last,
   output logic                       rsp_index_error,
   input  logic                       csr_write_enable,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [DIM_W-1:0]           csr_write_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int EXT_W  = (PROD_W > RESULT_W) ? PROD_W : RESULT_W;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (32'(value) > MAX_DIM) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = value;
      end
      return result;
   endfunction

   // configuration
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] ra, kd, cb;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_write_data;
            CSR_INNER_DIM: inner_dim_ff <= csr_write_data;
            CSR_COLS_B:    cols_b_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign ra = eff_dim(rows_a_ff);
   assign kd = eff_dim(inner_dim_ff);
   assign cb = eff_dim(cols_b_ff);

   // sequencer state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] j_ff, j_in;

   logic issue, a_we, b_we, out_load, out_error, done_take, out_free;
   logic [ADDR_W-1:0] w_addr, a_raddr, b_raddr;
   logic signed [VALUE_WIDTH-1:0] wr_value;

   // pipeline
   logic                          rd_valid_ff, rd_first_ff, rd_last_ff;
   logic signed [VALUE_WIDTH-1:0] a_rdata_ff, b_rdata_ff;
   logic                          mul_valid_ff, mul_first_ff, mul_last_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [EXT_W-1:0]       prod_ext;
   logic [RESULT_W-1:0]           acc_ff, acc_in;
   logic                          acc_done_ff, acc_done_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]           rsp_col_ff;
   logic [RESULT_W-1:0]        rsp_value_ff;
   logic                       rsp_last_ff, rsp_error_ff;

   logic signed [VALUE_WIDTH-1:0] mem_a [DEPTH];
   logic signed [VALUE_WIDTH-1:0] mem_b [DEPTH];

   assign wr_value = VALUE_WIDTH'(req_element_value);
   assign w_addr   = ADDR_W'(32'(req_row_index) * MAX_DIM + 32'(req_col_index));
   assign a_raddr  = ADDR_W'(32'(row_ff) * MAX_DIM + 32'(k_ff));
   assign b_raddr  = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(j_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (a_we) begin
         mem_a[w_addr] <= wr_value;
      end
      a_rdata_ff <= mem_a[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         mem_b[w_addr] <= wr_value;
      end
      b_rdata_ff <= mem_b[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
      end
      row_ff <= row_in;
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      a_we      = 1'b0;
      b_we      = 1'b0;
      out_load  = 1'b0;
      out_error = 1'b0;
      done_take = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (command_type'(req_command))
                  CMD_LOAD_A: begin
                     if ({1'b0, req_row_index} < ra && {1'b0, req_col_index} < kd) begin
                        a_we = 1'b1;
                     end else begin
                        state_in = ST_ERROR;
                     end
                  end
                  CMD_LOAD_B: begin
                     if ({1'b0, req_row_index} < kd && {1'b0, req_col_index} < cb) begin
                        b_we = 1'b1;
                     end else begin
                        state_in = ST_ERROR;
                     end
                  end
                  CMD_COMPUTE: begin
                     if ({1'b0, req_row_index} < ra) begin
                        row_in   = req_row_index;
                        k_in     = '0;
                        j_in     = '0;
                        state_in = ST_ISSUE;
                     end else begin
                        state_in = ST_ERROR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (k_ff == kd - DIM_W'(1)) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (acc_done_ff && out_free) begin
               out_load  = 1'b1;
               done_take = 1'b1;
               if (j_ff == cb - DIM_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + DIM_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_error = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // read, multiply and accumulate stages
   assign prod_ext    = EXT_W'(prod_ff);
   assign acc_in      = mul_first_ff ? prod_ext[RESULT_W-1:0]
                                     : acc_ff + prod_ext[RESULT_W-1:0];
   assign acc_done_in = (mul_valid_ff && mul_last_ff) || (acc_done_ff && !done_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         acc_done_ff  <= 1'b0;
      end else begin
         rd_valid_ff  <= issue;
         mul_valid_ff <= rd_valid_ff;
         acc_done_ff  <= acc_done_in;
      end
      rd_first_ff  <= (k_ff == '0);
      rd_last_ff   <= (k_ff == kd - DIM_W'(1));
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      prod_ff      <= a_rdata_ff * b_rdata_ff;
      if (mul_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_col_ff   <= out_error ? '0 : j_ff[IDX_W-1:0];
         rsp_value_ff <= out_error ? '0 : acc_ff;
         rsp_last_ff  <= out_error || (j_ff == cb - DIM_W'(1));
         rsp_error_ff <= out_error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_col   = rsp_col_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_index_error  = rsp_error_ff;

endmodule

// ===== design/mme_checker.sv =====
module mme_checker
   import mme_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [CMD_W-1:0]           req_command,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [IDX_W-1:0]           rsp_result_col,
   input logic signed [RESULT_W-1:0] rsp_result_value,
   input logic                       rsp_last,
   input logic                       rsp_index_error
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_col)
         && $stable(rsp_result_value) && $stable(rsp_last) && $stable(rsp_index_error))
      else $error("result changed while stalled");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_last)
      else $error("flagged result not marked last");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_result_col == '0 && rsp_result_value == '0)
      else $error("flagged result carries data");

   // a compute transaction keeps the block busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_COMPUTE |=> !req_ready)
      else $error("ready right after compute transaction");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_col   (rsp_result_col),
   .rsp_result_value (rsp_result_value),
   .rsp_last         (rsp_last),
   .rsp_index_error  (rsp_index_error)
);
